@@ rtl/mask_centerline_steering_top_macros.svh @@
// ----------------------------------------------------------------------------
// mask_centerline_steering_top_macros
// Assertion macros for the steering block.
// ----------------------------------------------------------------------------
`ifndef MASK_CENTERLINE_STEERING_TOP_MACROS_SVH
`define MASK_CENTERLINE_STEERING_TOP_MACROS_SVH

// same-cycle implication
`define MCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mcs_pkg.sv @@
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared widths, constants and control types of the steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

    localparam int COL_W        = 10;
    localparam int ROW_W_W      = 11;
    localparam int SCALE_W      = 16;
    localparam int SUM_W        = 22;
    localparam int ACC_W        = SUM_W + 2;
    localparam int HITS_W       = 11;
    localparam int SPEED_W      = 32;
    localparam int DRIVE_W      = 32;
    localparam int TURN_W       = 24;
    localparam int FWD_W        = 15;
    localparam int PROD_W       = SPEED_W + SCALE_W;
    localparam int RND_SHIFT    = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int DIV_N_W      = 36;
    localparam int DIV_W        = 32;
    localparam int DIV_CNT_W    = 3;
    localparam int RECIP5_SHIFT = 34;
    localparam int TURN_SHIFT   = 10;
    localparam int FWD_SHIFT    = 13;

    localparam logic [COL_W-1:0]          COL_MAX     = '1;
    localparam logic [HITS_W-1:0]         HITS_MAX    = '1;
    localparam logic signed [SUM_W-1:0]   SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]   SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [FWD_W-1:0]          FORWARD_CAP = 15'd19661;
    localparam logic [DIV_W-1:0]          RECIP5      = 32'hCCCC_CCCD;
    localparam logic [DIV_W-1:0]          HALF_TURN   = 32'd312;
    localparam logic [DIV_W-1:0]          HALF_FWD    = 32'd12;
    localparam logic [DIV_W-1:0]          HALF_SMOOTH = 32'd5;
    localparam logic [DIV_CNT_W-1:0]      STEPS_TURN   = 3'd4;
    localparam logic [DIV_CNT_W-1:0]      STEPS_FWD    = 3'd2;
    localparam logic [DIV_CNT_W-1:0]      STEPS_SMOOTH = 3'd1;
    localparam logic [ROW_W_W-1:0]        ROW_WIDTH_RST = 11'd640;
    localparam logic signed [SCALE_W-1:0] SCALE_RST   = 16'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH  = 2'd0,
        REG_FWD_SCALE  = 2'd1,
        REG_TURN_SCALE = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_TURN  = 2'd0,
        OP_FWD   = 2'd1,
        OP_STURN = 2'd2,
        OP_SFWD  = 2'd3
    } div_op_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_TURN  = 8'b0000_0100,
        S_FWD   = 8'b0000_1000,
        S_STURN = 8'b0001_0000,
        S_SFWD  = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic    pix_ready;
        logic    frame_clear;
        logic    div_start;
        div_op_t div_op;
        logic    mul;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic pix_valid;
        logic pix_frame_end;
        logic hits_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/mcs_if.sv @@
// ----------------------------------------------------------------------------
// mcs_if
// Channel interfaces: pixel input, drive output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcs_pix_if;
    logic valid;
    logic ready;
    logic contour_pixel;
    logic row_end;
    logic frame_end;

    modport source(output valid, contour_pixel, row_end, frame_end, input ready);
    modport sink(input valid, contour_pixel, row_end, frame_end, output ready);
endinterface

interface mcs_drive_if;
    import mcs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] forward_drive;
    logic signed [DRIVE_W-1:0] turn_drive;

    modport source(output valid, forward_drive, turn_drive, input ready);
    modport sink(input valid, forward_drive, turn_drive, output ready);
endinterface

interface mcs_cfg_if;
    import mcs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source(output valid, index, wdata, input ready);
    modport sink(input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/mcs_div.sv @@
// ----------------------------------------------------------------------------
// mcs_div
// Division by 625, 25 or 10 as repeated divide-by-five steps, one reciprocal
// multiply per cycle; the divide by 10 halves the dividend at load.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire mcs_pkg::div_op_t          op,
    input  wire logic [mcs_pkg::DIV_W-1:0] dividend,
    output logic                           done,
    output logic [mcs_pkg::DIV_W-1:0]      quotient
);
    import mcs_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     val_reg;

    logic [DIV_CNT_W-1:0] steps;
    logic                 halve;
    logic [2*DIV_W-1:0]   prod;
    logic [DIV_W-1:0]     val_next;

    always_comb
    begin
        unique case (op)
            OP_TURN:
            begin
                steps = STEPS_TURN;
                halve = 1'b0;
            end
            OP_FWD:
            begin
                steps = STEPS_FWD;
                halve = 1'b0;
            end
            OP_STURN, OP_SFWD:
            begin
                steps = STEPS_SMOOTH;
                halve = 1'b1;
            end
            default:
            begin
                steps = STEPS_SMOOTH;
                halve = 1'b1;
            end
        endcase
    end

    // exact floor(x / 5) for any 32-bit x
    assign prod     = (2*DIV_W)'(val_reg) * (2*DIV_W)'(RECIP5);
    assign val_next = DIV_W'(prod[2*DIV_W-1:RECIP5_SHIFT]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= halve ? {1'b0, dividend[DIV_W-1:1]} : dividend;
        end
        else if (busy_reg)
        begin
            val_reg <= val_next;
        end
    end

    assign done     = done_reg;
    assign quotient = val_reg;

endmodule

`default_nettype wire

@@ rtl/mcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcs_ctrl
// Sequencer for pixel intake and the frame-end arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mcs_pkg::status_t status,
    output mcs_pkg::cmd_t         cmd
);
    import mcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.div_op      = OP_TURN;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.pix_ready = 1'b1;
                if (status.pix_valid && status.pix_frame_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.hits_zero)
                begin
                    cmd.frame_clear = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_TURN;
                    state_next    = S_TURN;
                end
            end
            S_TURN:
            begin
                cmd.div_op = OP_FWD;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_FWD;
                end
            end
            S_FWD:
            begin
                cmd.div_op = OP_STURN;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_STURN;
                end
            end
            S_STURN:
            begin
                cmd.div_op = OP_SFWD;
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_SFWD;
                end
            end
            S_SFWD:
            begin
                if (status.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/mcs_dpath.sv @@
// ----------------------------------------------------------------------------
// mcs_dpath
// Row tracking, frame accumulators, speed arithmetic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_dpath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mcs_pix_if.sink            pix,
    mcs_drive_if.source        drive,
    mcs_cfg_if.sink            cfg,
    input  wire mcs_pkg::cmd_t cmd,
    output mcs_pkg::status_t   status
);
    import mcs_pkg::*;

    // configuration
    logic [ROW_W_W-1:0]        row_width_reg;
    logic signed [SCALE_W-1:0] forward_scale_reg;
    logic signed [SCALE_W-1:0] turn_scale_reg;

    // row and frame state
    logic [COL_W-1:0]          col_reg;
    logic [COL_W-1:0]          first_reg;
    logic [COL_W-1:0]          last_reg;
    logic                      hit_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [HITS_W-1:0]         hits_reg;
    logic signed [SPEED_W-1:0] smooth_forward_reg;
    logic signed [SPEED_W-1:0] smooth_turn_reg;

    // frame-end working registers
    logic signed [TURN_W-1:0]  turn_reg;
    logic [FWD_W-1:0]          fwd_reg;
    logic                      neg_reg;
    div_op_t                   op_reg;
    logic signed [PROD_W-1:0]  prod_f_reg;
    logic signed [PROD_W-1:0]  prod_t_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] fwd_drive_reg;
    logic signed [DRIVE_W-1:0] turn_drive_reg;

    logic                      take;
    logic                      close;
    logic                      hit_eff;
    logic [COL_W-1:0]          first_eff;
    logic [COL_W-1:0]          last_eff;
    logic [COL_W:0]            mid_sum;
    logic [COL_W:0]            mid2;
    logic signed [ACC_W-1:0]   acc;
    logic signed [SUM_W-1:0]   sum_sat;

    logic signed [DIV_N_W-1:0] num;
    logic [DIV_W-1:0]          half;
    logic [DIV_N_W-1:0]        num_mag;
    logic [DIV_W-1:0]          dividend;
    logic                      div_done;
    logic [DIV_W-1:0]          quotient;
    logic signed [DIV_W:0]     q_signed;
    logic signed [TURN_W:0]    turn_abs;
    logic signed [DIV_W:0]     fwd_diff;
    logic [FWD_W-1:0]          fwd_clamped;
    logic signed [DIV_N_W-1:0] st36;
    logic signed [DIV_N_W-1:0] t36;
    logic signed [DIV_N_W-1:0] sf36;
    logic signed [DIV_N_W-1:0] f36;
    logic                      out_free;

    function automatic logic signed [DRIVE_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0]          r;
        logic signed [PROD_W-RND_SHIFT-1:0] s;
        r = p + (p[PROD_W-1] ? PROD_W'(127) : PROD_W'(128));
        s = r[PROD_W-1:RND_SHIFT];
        if (s > $signed({{(PROD_W-RND_SHIFT-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}}))
        begin
            round_sat = {1'b0, {(DRIVE_W-1){1'b1}}};
        end
        else if (s < $signed({{(PROD_W-RND_SHIFT-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}}))
        begin
            round_sat = {1'b1, {(DRIVE_W-1){1'b0}}};
        end
        else
        begin
            round_sat = s[DRIVE_W-1:0];
        end
    endfunction

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg     <= ROW_WIDTH_RST;
            forward_scale_reg <= SCALE_RST;
            turn_scale_reg    <= SCALE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ROW_WIDTH:  row_width_reg     <= cfg.wdata[ROW_W_W-1:0];
                REG_FWD_SCALE:  forward_scale_reg <= $signed(cfg.wdata[SCALE_W-1:0]);
                REG_TURN_SCALE: turn_scale_reg    <= $signed(cfg.wdata[SCALE_W-1:0]);
                default:        ;
            endcase
        end
    end

    // ---------------- row tracking ----------------
    assign take      = pix.valid && cmd.pix_ready;
    assign pix.ready = cmd.pix_ready;
    assign close     = pix.row_end || pix.frame_end;
    assign hit_eff   = hit_reg || pix.contour_pixel;
    assign first_eff = (!hit_reg && pix.contour_pixel) ? col_reg : first_reg;
    assign last_eff  = pix.contour_pixel ? col_reg : last_reg;
    assign mid_sum   = {1'b0, first_eff} + {1'b0, last_eff};
    assign mid2      = {mid_sum[COL_W:1], 1'b0};
    assign acc       = ACC_W'(sum_reg) + $signed({{(ACC_W-COL_W-1){1'b0}}, mid2})
                       - $signed({{(ACC_W-ROW_W_W){1'b0}}, row_width_reg});

    always_comb
    begin
        if (acc > ACC_W'(SUM_MAX))
        begin
            sum_sat = SUM_MAX;
        end
        else if (acc < ACC_W'(SUM_MIN))
        begin
            sum_sat = SUM_MIN;
        end
        else
        begin
            sum_sat = acc[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            first_reg <= '0;
            last_reg  <= '0;
            hit_reg   <= 1'b0;
            sum_reg   <= '0;
            hits_reg  <= '0;
        end
        else if (take)
        begin
            if (close)
            begin
                if (hit_eff)
                begin
                    sum_reg <= sum_sat;
                    if (hits_reg != HITS_MAX)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                col_reg   <= '0;
                first_reg <= '0;
                last_reg  <= '0;
                hit_reg   <= 1'b0;
            end
            else
            begin
                if (col_reg != COL_MAX)
                begin
                    col_reg <= col_reg + 1'b1;
                end
                first_reg <= first_eff;
                last_reg  <= last_eff;
                hit_reg   <= hit_eff;
            end
        end
        else if (cmd.frame_clear || cmd.emit)
        begin
            sum_reg  <= '0;
            hits_reg <= '0;
        end
    end

    // ---------------- frame-end division ----------------
    assign st36 = DIV_N_W'(smooth_turn_reg);
    assign t36  = DIV_N_W'(turn_reg);
    assign sf36 = DIV_N_W'(smooth_forward_reg);
    assign f36  = $signed({{(DIV_N_W-FWD_W){1'b0}}, fwd_reg});

    always_comb
    begin
        unique case (cmd.div_op)
            OP_TURN:
            begin
                num  = $signed({{(DIV_N_W-SUM_W-TURN_SHIFT){sum_reg[SUM_W-1]}}, sum_reg,
                                {TURN_SHIFT{1'b0}}});
                half = HALF_TURN;
            end
            OP_FWD:
            begin
                num  = $signed({{(DIV_N_W-HITS_W-FWD_SHIFT){1'b0}}, hits_reg,
                                {FWD_SHIFT{1'b0}}});
                half = HALF_FWD;
            end
            OP_STURN:
            begin
                num  = (st36 <<< 1) + st36 + (t36 <<< 3) - t36;
                half = HALF_SMOOTH;
            end
            OP_SFWD:
            begin
                num  = (sf36 <<< 1) + sf36 + (f36 <<< 3) - f36;
                half = HALF_SMOOTH;
            end
            default:
            begin
                num  = '0;
                half = HALF_SMOOTH;
            end
        endcase
    end

    // magnitudes stay below 2^32 for every operation
    assign num_mag  = num[DIV_N_W-1] ? DIV_N_W'(-num) : DIV_N_W'(num);
    assign dividend = num_mag[DIV_W-1:0] + half;

    mcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .op       (cmd.div_op),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    assign q_signed = neg_reg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
    assign turn_abs = turn_reg[TURN_W-1] ? -$signed({turn_reg[TURN_W-1], turn_reg})
                                         : $signed({turn_reg[TURN_W-1], turn_reg});
    assign fwd_diff = $signed({1'b0, quotient})
                      - $signed({{(DIV_W-TURN_W){1'b0}}, turn_abs});

    always_comb
    begin
        if (fwd_diff < 0)
        begin
            fwd_clamped = '0;
        end
        else if (fwd_diff > $signed({{(DIV_W-FWD_W+1){1'b0}}, FORWARD_CAP}))
        begin
            fwd_clamped = FORWARD_CAP;
        end
        else
        begin
            fwd_clamped = fwd_diff[FWD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_forward_reg <= '0;
            smooth_turn_reg    <= '0;
        end
        else if (div_done)
        begin
            if (op_reg == OP_STURN)
            begin
                smooth_turn_reg <= q_signed[SPEED_W-1:0];
            end
            else if (op_reg == OP_SFWD)
            begin
                smooth_forward_reg <= q_signed[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= num[DIV_N_W-1];
            op_reg  <= cmd.div_op;
        end
        if (div_done && op_reg == OP_TURN)
        begin
            turn_reg <= q_signed[TURN_W-1:0];
        end
        if (div_done && op_reg == OP_FWD)
        begin
            fwd_reg <= fwd_clamped;
        end
        if (cmd.mul)
        begin
            prod_f_reg <= smooth_forward_reg * forward_scale_reg;
            prod_t_reg <= smooth_turn_reg * turn_scale_reg;
        end
    end

    // ---------------- output register ----------------
    assign out_free = !out_valid_reg || drive.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (drive.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            fwd_drive_reg  <= round_sat(prod_f_reg);
            turn_drive_reg <= round_sat(prod_t_reg);
        end
    end

    assign drive.valid         = out_valid_reg;
    assign drive.forward_drive = fwd_drive_reg;
    assign drive.turn_drive    = turn_drive_reg;

    assign status.pix_valid     = pix.valid;
    assign status.pix_frame_end = pix.frame_end;
    assign status.hits_zero     = (hits_reg == '0);
    assign status.div_done      = div_done;
    assign status.out_free      = out_free;

endmodule

`default_nettype wire

@@ rtl/mask_centerline_steering_top.sv @@
// ----------------------------------------------------------------------------
// mask_centerline_steering_top
// Steering speeds from a raster of one-bit contour pixels.
//
//   channel  dir  payload                              handshake
//   pix      in   contour_pixel, row_end, frame_end    valid/ready
//   drive    out  forward_drive, turn_drive (Q16.16)   valid/ready
//   cfg      in   index, wdata                         valid/ready, always ready
//
// Pixels are taken one per cycle while pix.ready is high. A frame end with hit
// rows holds pix.ready low through the check state, the shared divide-by-five
// unit (turn, forward and the two smoothing passes), the multiply state and the
// output load. A frame end with no hit rows costs the check state only.
// A waiting result does not stall pixel intake; only the next frame's result
// waits for the output register. Reset clears the control, row, frame and
// smoothing state and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mask_centerline_steering_top_macros.svh"

module mask_centerline_steering_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcs_pix_if.sink     pix,
    mcs_drive_if.source drive,
    mcs_cfg_if.sink     cfg
);
    import mcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    mcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mcs_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .drive  (drive),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

    `MCS_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free, "result loaded over a pending beat")
    `MCS_ASSERT_NEXT(a_frame_stall, pix.valid && pix.ready && pix.frame_end, !pix.ready,
        "pixel taken right after a frame end")
    `MCS_ASSERT_NEXT(a_emit_valid, cmd.emit, drive.valid, "emitted result not presented")
    `MCS_ASSERT_NOW(a_no_start_busy, cmd.div_start, !pix.ready,
        "divider started while taking pixels")

endmodule

`default_nettype wire
